[src/fsfd_pkg.sv]
package fsfd_pkg;

	// packet framing
	localparam int BODY_BYTES    = 12;
	localparam int QUALITY_INDEX = 8;
	localparam int CNT_W         = $clog2(BODY_BYTES);

	localparam logic [7:0] SYNC_FIRST    = 8'hFE;
	localparam logic [7:0] SYNC_SECOND   = 8'h0A;
	localparam logic [7:0] QUALITY_RESET = 8'd245;

	// arithmetic widths
	localparam int FRAC_BITS = 8;
	localparam int RAW_W     = 16;
	localparam int MS_W      = 7;
	localparam int VEL_W     = 21;
	localparam int DIV_W     = 10;                 // holds 1000 and 10 * 65
	localparam int NUM_W     = RAW_W + FRAC_BITS;  // |flow| << FRAC_BITS
	localparam int DVD_W     = 2 * ((NUM_W + 1) / 2);
	localparam int DIV_STEPS = DVD_W / 2;          // two quotient bits per cycle
	localparam int STEP_W    = $clog2(DIV_STEPS + 1);
	localparam int RES_W     = (NUM_W + 1 > VEL_W) ? NUM_W + 1 : VEL_W;

	localparam logic [DIV_W-1:0] US_PER_MS = DIV_W'(1000);
	localparam logic [DIV_W-1:0] VEL_SCALE = DIV_W'(10);

	// microseconds to ms: multiply by ceil(2^MS_SHIFT / 1000), keep the top bits;
	// exact for every 16-bit time
	localparam int MS_SHIFT = 26;
	localparam int RECIP_W  = 17;
	localparam int PROD_W   = RAW_W + RECIP_W;
	localparam logic [RECIP_W-1:0] MS_RECIP =
		RECIP_W'(((1 << MS_SHIFT) + int'(US_PER_MS) - 1) / int'(US_PER_MS));

	// job queue between parser and divider side
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	typedef struct packed {
		logic [RAW_W-1:0] flow_x;
		logic [RAW_W-1:0] flow_y;
		logic [RAW_W-1:0] time_raw;
		logic             quality_ok;
	} job_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [NUM_W-1:0] quotient;
	} div_rsp_t;

	// magnitude of a signed 16-bit flow value, scaled by the fraction bits
	function automatic logic [NUM_W-1:0] scaled_mag(input logic [RAW_W-1:0] v);
		logic [RAW_W-1:0] m;
		m = v[RAW_W-1] ? RAW_W'(-v) : v;
		return NUM_W'(m) << FRAC_BITS;
	endfunction

	// apply the sign back, truncated to the output width
	function automatic logic signed [VEL_W-1:0] signed_vel(input logic sgn,
		input logic [NUM_W-1:0] q);
		logic [RES_W-1:0] e;
		e = RES_W'(q);
		if (sgn) begin
			e = RES_W'(-e);
		end
		return $signed(e[VEL_W-1:0]);
	endfunction

endpackage

[src/fsfd_front.sv]
module fsfd_front
	import fsfd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic       in_accept,
	input  logic [7:0] in_byte,
	output logic       push,
	output job_t       push_job
);

	localparam logic [1:0] PH_HUNT   = 2'd0;
	localparam logic [1:0] PH_SECOND = 2'd1;
	localparam logic [1:0] PH_BODY   = 2'd2;

	logic [1:0]       phase_q;
	logic [CNT_W-1:0] count_q;
	logic [RAW_W-1:0] flow_x_q;
	logic [RAW_W-1:0] flow_y_q;
	logic [RAW_W-1:0] time_q;
	logic [7:0]       good_code_q;
	logic             in_body;

	assign in_body = in_accept && (phase_q == PH_BODY);

	// quality code register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			good_code_q <= QUALITY_RESET;
		end else if (cfg_we) begin
			good_code_q <= cfg_wdata;
		end
	end

	// sync hunt and body counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			count_q <= '0;
		end else if (in_accept) begin
			case (phase_q)
				PH_HUNT: begin
					if (in_byte == SYNC_FIRST) phase_q <= PH_SECOND;
				end
				PH_SECOND: begin
					if (in_byte == SYNC_SECOND) begin
						phase_q <= PH_BODY;
						count_q <= '0;
					end else if (in_byte != SYNC_FIRST) begin
						phase_q <= PH_HUNT;
					end
				end
				PH_BODY: begin
					if (count_q == CNT_W'(BODY_BYTES - 1)) begin
						phase_q <= PH_HUNT;
						count_q <= '0;
					end else begin
						count_q <= count_q + 1'b1;
					end
				end
				default: phase_q <= PH_HUNT;
			endcase
		end
	end

	// little-endian field capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flow_x_q <= '0;
			flow_y_q <= '0;
			time_q   <= '0;
		end else if (in_body) begin
			case (count_q)
				CNT_W'(0): flow_x_q[7:0]  <= in_byte;
				CNT_W'(1): flow_x_q[15:8] <= in_byte;
				CNT_W'(2): flow_y_q[7:0]  <= in_byte;
				CNT_W'(3): flow_y_q[15:8] <= in_byte;
				CNT_W'(4): time_q[7:0]    <= in_byte;
				CNT_W'(5): time_q[15:8]   <= in_byte;
				default: ;
			endcase
		end
	end

	// quality byte hands the packet's job to the divider side
	assign push                = in_body && (count_q == CNT_W'(QUALITY_INDEX));
	assign push_job.flow_x     = flow_x_q;
	assign push_job.flow_y     = flow_y_q;
	assign push_job.time_raw   = time_q;
	assign push_job.quality_ok = (in_byte == good_code_q);

endmodule

[src/fsfd_queue.sv]
module fsfd_queue
	import fsfd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output logic full,
	output logic empty,
	output job_t head
);

	job_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_job;
	end

	// pointers wrap naturally at a power-of-two depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

[src/fsfd_divider.sv]
module fsfd_divider
	import fsfd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [DVD_W-1:0]  work_q;
	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  divisor_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [DVD_W-1:0]  work_d;
	logic [DIV_W-1:0]  rem_d;

	// two restoring steps per cycle; quotient bits shift into the low end
	always_comb begin
		logic [DIV_W:0] trial;
		work_d = work_q;
		rem_d  = rem_q;
		for (int i = 0; i < 2; i++) begin
			trial  = {rem_d, work_d[DVD_W-1]};
			work_d = work_d << 1;
			if (trial >= {1'b0, divisor_q}) begin
				rem_d     = DIV_W'(trial - {1'b0, divisor_q});
				work_d[0] = 1'b1;
			end else begin
				rem_d = DIV_W'(trial);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			work_q    <= DVD_W'(req.dividend);
			rem_q     <= '0;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			work_q <= work_d;
			rem_q  <= rem_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(DIV_STEPS);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = work_q[NUM_W-1:0];

endmodule

[src/fsfd_back.sv]
module fsfd_back
	import fsfd_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    q_empty,
	input  job_t                    q_head,
	output logic                    pop,
	output div_req_t                div_req,
	input  div_rsp_t                div_rsp,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [VEL_W-1:0] vel_x,
	output logic signed [VEL_W-1:0] vel_y,
	output logic [MS_W-1:0]         interval_ms,
	output logic                    quality_ok,
	output logic                    zero_interval
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MS   = 3'd1;
	localparam logic [2:0] ST_X    = 3'd2;
	localparam logic [2:0] ST_Y    = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0]              state_q;
	job_t                    job_q;
	logic [MS_W-1:0]         ms_q;
	logic signed [VEL_W-1:0] vx_q;
	logic signed [VEL_W-1:0] vy_q;
	logic                    out_valid_q;
	logic signed [VEL_W-1:0] vel_x_q;
	logic signed [VEL_W-1:0] vel_y_q;
	logic [MS_W-1:0]         ms_out_q;
	logic                    qual_out_q;
	logic                    zero_out_q;
	logic [PROD_W-1:0]       ms_prod;
	logic [MS_W-1:0]         ms_new;
	logic [DIV_W-1:0]        scale_div;
	logic                    out_free;
	logic                    load_out;

	// interval in whole ms by reciprocal multiply, taken at the pop
	assign ms_prod   = PROD_W'(q_head.time_raw) * PROD_W'(MS_RECIP);
	assign ms_new    = ms_prod[MS_SHIFT +: MS_W];
	assign scale_div = DIV_W'(ms_q) * VEL_SCALE;
	assign out_free  = !out_valid_q || !out_stall;
	assign load_out  = (state_q == ST_OUT) && out_free;
	assign pop       = (state_q == ST_IDLE) && !q_empty;

	// divider requests: X once the interval is known, then Y
	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = scaled_mag(job_q.flow_x);
		div_req.divisor  = scale_div;
		case (state_q)
			ST_MS: begin
				div_req.start = (ms_q != '0);
			end
			ST_X: begin
				div_req.start    = div_rsp.done;
				div_req.dividend = scaled_mag(job_q.flow_y);
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (!q_empty) state_q <= ST_MS;
				ST_MS:   state_q <= (ms_q == '0) ? ST_OUT : ST_X;
				ST_X:    if (div_rsp.done) state_q <= ST_Y;
				ST_Y:    if (div_rsp.done) state_q <= ST_OUT;
				ST_OUT:  if (out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// working values
	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= q_head;
			ms_q  <= ms_new;
			vx_q  <= '0;
			vy_q  <= '0;
		end
		if (state_q == ST_X && div_rsp.done) vx_q <= signed_vel(job_q.flow_x[RAW_W-1], div_rsp.quotient);
		if (state_q == ST_Y && div_rsp.done) vy_q <= signed_vel(job_q.flow_y[RAW_W-1], div_rsp.quotient);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			vel_x_q    <= vx_q;
			vel_y_q    <= vy_q;
			ms_out_q   <= ms_q;
			qual_out_q <= job_q.quality_ok;
			zero_out_q <= (ms_q == '0);
		end
	end

	assign out_valid     = out_valid_q;
	assign vel_x         = vel_x_q;
	assign vel_y         = vel_y_q;
	assign interval_ms   = ms_out_q;
	assign quality_ok    = qual_out_q;
	assign zero_interval = zero_out_q;

endmodule

[src/flow_sensor_frame_decoder_top.sv]
// Optical flow sensor frame decoder.
// Input channel: one serial byte per word (in_valid / in_stall). The parser
// hunts for the 0xFE 0x0A sync pair, then collects the packet body.
// Output channel: one word per packet, from the job queued at its quality
// byte: vel_x, vel_y (signed, FRAC_BITS fraction bits), interval_ms,
// quality_ok and zero_interval (out_valid / out_stall).
// cfg_we / cfg_wdata write the good quality code; write only while idle.
// Bytes are taken one per cycle while the two-entry job queue has room;
// in_stall is high for any byte while the queue is full.
// The interval comes from a reciprocal multiply at the pop; each packet then
// takes two passes of the shared radix-4 divider (X, then Y), none when the
// interval is zero. The parser keeps taking bytes of the next packets while
// the divider works, as long as the job queue has room.
// The output register lets the divider start the next packet while a result
// waits on out_stall. Reset clears the parser, queue and output valid, and
// restores the quality code to 245.
module flow_sensor_frame_decoder_top
	import fsfd_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [7:0]              cfg_wdata,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [7:0]              in_byte,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [VEL_W-1:0] vel_x,
	output logic signed [VEL_W-1:0] vel_y,
	output logic [MS_W-1:0]         interval_ms,
	output logic                    quality_ok,
	output logic                    zero_interval
);

	logic     push;
	job_t     push_job;
	logic     pop;
	logic     q_full;
	logic     q_empty;
	job_t     q_head;
	div_req_t div_req;
	div_rsp_t div_rsp;

	assign in_stall = q_full;

	fsfd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_accept (in_valid && !in_stall),
		.in_byte   (in_byte),
		.push      (push),
		.push_job  (push_job)
	);

	fsfd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.full     (q_full),
		.empty    (q_empty),
		.head     (q_head)
	);

	fsfd_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	fsfd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_head        (q_head),
		.pop           (pop),
		.div_req       (div_req),
		.div_rsp       (div_rsp),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.vel_x         (vel_x),
		.vel_y         (vel_y),
		.interval_ms   (interval_ms),
		.quality_ok    (quality_ok),
		.zero_interval (zero_interval)
	);

endmodule

[src/fsfd_checker.sv]
module fsfd_checker
	import fsfd_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic signed [VEL_W-1:0] vel_x,
	input logic signed [VEL_W-1:0] vel_y,
	input logic [MS_W-1:0]         interval_ms,
	input logic                    zero_interval
);

	// a stalled word stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output word dropped while stalled");

	// zero flag matches the interval
	a_zero_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (zero_interval == (interval_ms == '0)))
		else $error("zero_interval disagrees with interval_ms");

	// zero interval forces zero velocities
	a_zero_vel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_interval |-> (vel_x == '0) && (vel_y == '0))
		else $error("nonzero velocity with zero interval");

	// 16-bit microseconds never exceed 65 ms
	a_ms_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (interval_ms <= MS_W'(65)))
		else $error("interval_ms out of range");

endmodule

bind flow_sensor_frame_decoder_top fsfd_checker u_fsfd_checker (.*);
